[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define SLD_ASSERT(lbl, clk, rst, prop) \
    lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
        else $error("assertion failed");

// Trigger implies property on the next edge.
`define SLD_ASSERT_NEXT(lbl, clk, rst, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
        else $error("assertion failed");

`endif

[hdl/sld_pkg.sv]
package sld_pkg;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] search_key;
        logic [12:0] payload_length;
        logic [12:0] needed_bytes;
    } t_in;

    typedef struct packed {
        logic [1:0]  result_status;
        logic [11:0] tuple_start;
        logic [12:0] tuple_end;
        logic [12:0] written_bytes;
        logic [8:0]  lend_count;
        logic        did_compact;
    } t_out;

    typedef struct packed {
        logic [15:0] key;
        logic [11:0] off;
        logic [12:0] len;
        logic        dead;
    } t_slot;

    localparam logic [2:0] OP_SEARCH    = 3'd0;
    localparam logic [2:0] OP_INSERT    = 3'd1;
    localparam logic [2:0] OP_DELETE    = 3'd2;
    localparam logic [2:0] OP_LEND_TAIL = 3'd3;
    localparam logic [2:0] OP_LEND_HEAD = 3'd4;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_MISS      = 2'd1;
    localparam logic [1:0] ST_TRUNC     = 2'd2;
    localparam logic [1:0] ST_REFUSED   = 2'd3;

    localparam logic CFG_UNDERFLOW = 1'b0;
    localparam logic CFG_MAX_ENTRY = 1'b1;

endpackage

[hdl/sld_slot_ram.sv]
module sld_slot_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  sld_pkg::t_slot     i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output sld_pkg::t_slot     o_rdata
);

    sld_pkg::t_slot r_mem [DEPTH];
    sld_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/slotted_leaf_directory.sv]
// channel  direction  valid        stall        payload
// in       input      i_in_valid   o_in_stall   i_in_data  (sld_pkg::t_in)
// out      output     o_out_valid  i_out_stall  o_out_data (sld_pkg::t_out)
// cfg      input      i_cfg_we     -            i_cfg_index, i_cfg_data
// Each transaction passes dispatch and finish; a scan reads one slot RAM word per slot
// visited, alternating read and evaluate states; insert may add a compaction pass, a
// key scan and a shift of the slots above the insert position.
// Reset (synchronous, active low) clears count and garbage, presets config; no RAM clear.
// Input is stalled while a transaction is in work; one result may wait in the output.
`include "assert_macros.svh"

module slotted_leaf_directory #(
    parameter int PAGE_BYTES         = 4096,
    parameter int MAX_SLOTS          = 256,
    parameter int SLOT_BYTES         = 6,
    parameter int TUPLE_HEADER_BYTES = 10,
    parameter int HEADER_BYTES       = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sld_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sld_pkg::t_out  o_out_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [12:0]    i_cfg_data
);

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int MIN_ENTRY = SLOT_BYTES + TUPLE_HEADER_BYTES;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_EV, S_COMP_RD, S_COMP_EV,
        S_FIND_RD, S_FIND_EV, S_PLACE, S_SHIFT_RD, S_SHIFT_EV, S_PUT,
        S_LEND_RD, S_LEND_EV, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic [2:0]  r_op, n_op;
    logic [15:0] r_key, n_key;
    logic [12:0] r_plen, n_plen;
    logic [12:0] r_need, n_need;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [11:0] r_fe, n_fe;
    logic [12:0] r_garb, n_garb;
    logic [12:0] r_thr, n_thr;
    logic [12:0] r_maxe, n_maxe;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_left, n_left;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_ans, n_ans;
    logic [11:0] r_cfe, n_cfe;
    logic signed [17:0] r_used, n_used;
    logic [15:0] r_space, n_space;
    logic [8:0]  r_taken, n_taken;
    logic [15:0] r_ps, n_ps;
    logic        r_reuse, n_reuse;
    logic        r_prev_dead, n_prev_dead;
    sld_pkg::t_out r_res, n_res;
    sld_pkg::t_out r_out, n_out;
    logic        r_ovalid, n_ovalid;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    sld_pkg::t_slot mem_wdata;
    sld_pkg::t_slot rd;

    sld_slot_ram #(.DEPTH(MAX_SLOTS), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd)
    );

    logic [15:0] raw, data;
    logic signed [17:0] av, total, data_s, lend_u, thr_s;
    logic [13:0] gsum;
    logic [13:0] sz;
    logic [15:0] space_nx;
    logic [11:0] off_c, off_p;
    logic [15:0] wr;

    always_comb begin
        raw    = 16'(MIN_ENTRY) + 16'(r_plen);
        data   = (raw < 16'(r_maxe)) ? raw : 16'(r_maxe);
        av     = 18'(r_fe) + 18'sd1 - 18'(HEADER_BYTES) - 18'(r_cnt) * 18'(SLOT_BYTES);
        total  = av + 18'(r_garb);
        data_s = 18'(data);
        gsum   = 14'(r_garb) + 14'(rd.len);
        sz     = 14'(rd.len) + 14'(SLOT_BYTES);
        lend_u = r_used - 18'(sz);
        thr_s  = 18'(r_thr);
        space_nx = r_space + 16'(sz);
        off_c  = r_cfe - rd.len[11:0] + 12'd1;
        off_p  = r_fe - r_ps[11:0] + 12'd1;
        wr     = r_ps - 16'(TUPLE_HEADER_BYTES);
    end

    always_comb begin
        n_state = r_state; n_op = r_op; n_key = r_key; n_plen = r_plen; n_need = r_need;
        n_cnt = r_cnt; n_fe = r_fe; n_garb = r_garb; n_thr = r_thr; n_maxe = r_maxe;
        n_idx = r_idx; n_left = r_left; n_n = r_n; n_ans = r_ans; n_cfe = r_cfe;
        n_used = r_used; n_space = r_space; n_taken = r_taken; n_ps = r_ps;
        n_reuse = r_reuse; n_prev_dead = r_prev_dead; n_res = r_res;
        n_out = r_out; n_ovalid = r_ovalid;
        mem_we = 1'b0; mem_waddr = r_idx[AW-1:0]; mem_wdata = rd;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                sld_pkg::CFG_UNDERFLOW: n_thr  = i_cfg_data;
                sld_pkg::CFG_MAX_ENTRY: n_maxe = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_in_data.opcode; n_key = i_in_data.search_key;
                    n_plen = i_in_data.payload_length; n_need = i_in_data.needed_bytes;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res = '0;
                n_res.result_status = sld_pkg::ST_MISS;
                n_idx = '0; n_left = r_cnt; n_state = S_FIN;
                priority case (r_op)
                    sld_pkg::OP_SEARCH, sld_pkg::OP_DELETE: begin
                        n_state = S_SCAN_RD;
                    end
                    sld_pkg::OP_INSERT: begin
                        n_res.result_status = sld_pkg::ST_REFUSED;
                        if (data >= 16'(MIN_ENTRY) && total >= 18'(MIN_ENTRY)) begin
                            if (data_s <= total) begin
                                n_res.did_compact = (data_s > av);
                                n_ps = data - 16'(SLOT_BYTES);
                            end else begin
                                n_res.did_compact = (av < total);
                                n_ps = 16'(total) - 16'(SLOT_BYTES);
                            end
                            n_n = '0; n_cfe = 12'(PAGE_BYTES - 1); n_prev_dead = 1'b0;
                            n_state = n_res.did_compact ? S_COMP_RD : S_FIND_RD;
                        end
                    end
                    sld_pkg::OP_LEND_TAIL, sld_pkg::OP_LEND_HEAD: begin
                        n_used = 18'(PAGE_BYTES) - av - 18'(r_garb) - 18'(HEADER_BYTES);
                        n_space = '0; n_taken = '0;
                        n_idx = (r_op == sld_pkg::OP_LEND_TAIL) ? r_cnt - 1'b1 : '0;
                        if (r_need != 13'd0 && r_cnt != '0) begin
                            n_state = S_LEND_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN_RD: n_state = (r_left == '0) ? S_FIN : S_SCAN_EV;
            S_SCAN_EV: begin
                if (!rd.dead && rd.key >= r_key) begin
                    n_state = S_FIN;
                    if (rd.key == r_key) begin
                        n_res.result_status = sld_pkg::ST_DONE;
                        if (r_op == sld_pkg::OP_SEARCH) begin
                            n_res.tuple_start = rd.off;
                            n_res.tuple_end = 13'(14'(rd.off) + 14'(rd.len));
                        end else begin
                            mem_we = 1'b1;
                            mem_wdata.dead = 1'b1;
                            n_garb = gsum[13] ? 13'h1fff : gsum[12:0];
                        end
                    end
                end else begin
                    n_idx = r_idx + 1'b1; n_left = r_left - 1'b1; n_state = S_SCAN_RD;
                end
            end
            S_COMP_RD: begin
                if (r_left == '0) begin
                    n_cnt = r_n; n_fe = r_cfe; n_garb = '0;
                    n_idx = '0; n_left = r_n; n_state = S_FIND_RD;
                end else begin
                    n_state = S_COMP_EV;
                end
            end
            S_COMP_EV: begin
                if (!rd.dead) begin
                    mem_we = 1'b1; mem_waddr = r_n[AW-1:0];
                    mem_wdata.off = off_c; mem_wdata.dead = 1'b0;
                    n_cfe = off_c - 12'd1; n_n = r_n + 1'b1;
                end
                n_idx = r_idx + 1'b1; n_left = r_left - 1'b1; n_state = S_COMP_RD;
            end
            S_FIND_RD: begin
                if (r_left == '0) begin
                    n_ans = r_cnt; n_reuse = r_prev_dead; n_state = S_PLACE;
                end else begin
                    n_state = S_FIND_EV;
                end
            end
            S_FIND_EV: begin
                if (!rd.dead && rd.key > r_key) begin
                    n_ans = r_idx; n_reuse = r_prev_dead; n_state = S_PLACE;
                end else begin
                    n_prev_dead = rd.dead;
                    n_idx = r_idx + 1'b1; n_left = r_left - 1'b1; n_state = S_FIND_RD;
                end
            end
            S_PLACE: begin
                if (r_reuse) begin
                    n_ans = r_ans - 1'b1; n_state = S_PUT;
                end else if (r_cnt >= CW'(MAX_SLOTS)) begin
                    n_res.result_status = sld_pkg::ST_REFUSED; n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    n_idx = r_cnt - 1'b1;
                    n_state = (r_ans == r_cnt) ? S_PUT : S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_EV;
            S_SHIFT_EV: begin
                mem_we = 1'b1; mem_waddr = AW'(r_idx + 1'b1);
                if (r_idx == r_ans) begin
                    n_state = S_PUT;
                end else begin
                    n_idx = r_idx - 1'b1; n_state = S_SHIFT_RD;
                end
            end
            S_PUT: begin
                mem_we = 1'b1; mem_waddr = r_ans[AW-1:0];
                mem_wdata.key = r_key; mem_wdata.off = off_p;
                mem_wdata.len = r_ps[12:0]; mem_wdata.dead = 1'b0;
                n_fe = off_p - 12'd1;
                n_res.tuple_start = off_p;
                n_res.written_bytes = wr[12:0];
                n_res.result_status = (wr < 16'(r_plen)) ? sld_pkg::ST_TRUNC
                                                          : sld_pkg::ST_DONE;
                n_state = S_FIN;
            end
            S_LEND_RD: n_state = (r_left == '0) ? S_FIN : S_LEND_EV;
            S_LEND_EV: begin
                n_idx = (r_op == sld_pkg::OP_LEND_TAIL) ? r_idx - 1'b1 : r_idx + 1'b1;
                n_left = r_left - 1'b1; n_state = S_LEND_RD;
                if (!rd.dead) begin
                    if (lend_u <= thr_s) begin
                        n_state = S_FIN;
                    end else if (space_nx >= 16'(r_need)) begin
                        n_res.result_status = sld_pkg::ST_DONE;
                        n_res.lend_count = r_taken + 9'd1;
                        n_state = S_FIN;
                    end else begin
                        n_used = lend_u; n_space = space_nx; n_taken = r_taken + 9'd1;
                    end
                end
            end
            S_FIN: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_out = r_res; n_ovalid = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_fe <= 12'(PAGE_BYTES - 1);
            r_garb <= '0;
            r_thr <= 13'd1024;
            r_maxe <= 13'd2048;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_fe <= n_fe;
            r_garb <= n_garb;
            r_thr <= n_thr;
            r_maxe <= n_maxe;
            r_ovalid <= n_ovalid;
        end
        r_op <= n_op; r_key <= n_key; r_plen <= n_plen; r_need <= n_need;
        r_idx <= n_idx; r_left <= n_left; r_n <= n_n; r_ans <= n_ans; r_cfe <= n_cfe;
        r_used <= n_used; r_space <= n_space; r_taken <= n_taken; r_ps <= n_ps;
        r_reuse <= n_reuse; r_prev_dead <= n_prev_dead; r_res <= n_res; r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `SLD_ASSERT_NEXT(a_accept_dispatch, i_clk, !i_rst_n, i_in_valid && !o_in_stall, r_state == S_DISPATCH)
    `SLD_ASSERT(a_cnt_bound, i_clk, !i_rst_n, r_cnt <= CW'(MAX_SLOTS))
    `SLD_ASSERT(a_shift_inside, i_clk, !i_rst_n, (r_state != S_SHIFT_EV) || (r_idx + 1'b1 < r_cnt))
    `SLD_ASSERT_NEXT(a_fin_loads, i_clk, !i_rst_n, r_state == S_FIN && !r_ovalid, o_out_valid)

endmodule

[tb/sv/slotted_leaf_directory_tb.sv]
module slotted_leaf_directory_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE      = 4096;
    localparam int SLOTS     = 256;
    localparam int SLOT_SZ   = 6;
    localparam int TUP_HDR   = 10;
    localparam int HDR       = 32;
    localparam int IDLE_LIMIT = 20000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    sld_pkg::t_in   i_in_data;
    logic           o_out_valid;
    logic           i_out_stall;
    sld_pkg::t_out  o_out_data;
    logic           i_cfg_we;
    logic           i_cfg_index;
    logic [12:0]    i_cfg_data;

    slotted_leaf_directory u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow page state
    sld_pkg::t_slot dir_q [SLOTS];
    int          dir_cnt;
    int          page_free_end;
    int          page_garbage;
    int          thresh_reg;
    int          max_entry_reg;

    sld_pkg::t_out pending_results[$];
    int          fail_count;
    int          result_count;
    int          item_count;
    int          idle_cycles;
    bit          hold_off_req;
    int          hold_off_len;
    int          trunc_seen, refuse_seen, compact_seen, lend_ok_seen;
    logic [15:0] used_keys[$];

    function automatic int avail_bytes();
        return page_free_end + 1 - HDR - dir_cnt * SLOT_SZ;
    endfunction

    function automatic void compact_page();
        int fe;
        int n;
        int off;
        fe = PAGE - 1;
        n = 0;
        for (int i = 0; i < dir_cnt; i++) begin
            if (!dir_q[i].dead) begin
                off = (fe - int'(dir_q[i].len) + 1) & 12'hfff;
                dir_q[n].key  = dir_q[i].key;
                dir_q[n].len  = dir_q[i].len;
                dir_q[n].off  = off[11:0];
                dir_q[n].dead = 1'b0;
                fe = (off - 1) & 12'hfff;
                n++;
            end
        end
        dir_cnt = n;
        page_free_end = fe;
        page_garbage = 0;
    endfunction

    function automatic sld_pkg::t_out apply_page_op(sld_pkg::t_in op);
        sld_pkg::t_out r;
        int   i, ans, pos, raw, data, av, total, ps, off, used, space, taken, sz, g;
        bit   comp, reuse;
        r = '0;
        r.result_status = sld_pkg::ST_MISS;
        case (op.opcode)
            sld_pkg::OP_SEARCH, sld_pkg::OP_DELETE: begin
                i = dir_cnt;
                for (int k = 0; k < dir_cnt; k++) begin
                    if (!dir_q[k].dead && dir_q[k].key >= op.search_key) begin
                        i = k;
                        break;
                    end
                end
                if (i < dir_cnt && dir_q[i].key == op.search_key) begin
                    r.result_status = sld_pkg::ST_DONE;
                    if (op.opcode == sld_pkg::OP_SEARCH) begin
                        r.tuple_start = dir_q[i].off;
                        r.tuple_end   = 13'(int'(dir_q[i].off) + int'(dir_q[i].len));
                    end else begin
                        g = page_garbage + int'(dir_q[i].len);
                        page_garbage = (g > 8191) ? 8191 : g;
                        dir_q[i].dead = 1'b1;
                    end
                end
            end
            sld_pkg::OP_INSERT: begin
                raw = SLOT_SZ + TUP_HDR + int'(op.payload_length);
                data = (raw < max_entry_reg) ? raw : max_entry_reg;
                av = avail_bytes();
                total = av + page_garbage;
                r.result_status = sld_pkg::ST_REFUSED;
                if (data >= SLOT_SZ + TUP_HDR && total >= SLOT_SZ + TUP_HDR) begin
                    if (data <= total) begin
                        comp = data > av;
                        ps = data - SLOT_SZ;
                    end else begin
                        comp = av < total;
                        ps = total - SLOT_SZ;
                    end
                    if (comp) begin
                        compact_page();
                        r.did_compact = 1'b1;
                    end
                    ans = dir_cnt;
                    for (int k = 0; k < dir_cnt; k++) begin
                        if (!dir_q[k].dead && dir_q[k].key > op.search_key) begin
                            ans = k;
                            break;
                        end
                    end
                    reuse = ans > 0 && dir_q[ans - 1].dead;
                    if (reuse || dir_cnt < SLOTS) begin
                        if (reuse) begin
                            pos = ans - 1;
                        end else begin
                            for (int k = dir_cnt; k > ans; k--) dir_q[k] = dir_q[k - 1];
                            pos = ans;
                            dir_cnt++;
                        end
                        off = (page_free_end - ps + 1) & 12'hfff;
                        dir_q[pos].key  = op.search_key;
                        dir_q[pos].off  = off[11:0];
                        dir_q[pos].len  = ps[12:0];
                        dir_q[pos].dead = 1'b0;
                        page_free_end = (off - 1) & 12'hfff;
                        r.written_bytes = 13'(ps - TUP_HDR);
                        r.tuple_start = off[11:0];
                        r.result_status = (ps - TUP_HDR < int'(op.payload_length))
                                          ? sld_pkg::ST_TRUNC : sld_pkg::ST_DONE;
                    end
                end
            end
            sld_pkg::OP_LEND_TAIL, sld_pkg::OP_LEND_HEAD: begin
                used = PAGE - avail_bytes() - page_garbage - HDR;
                space = 0;
                taken = 0;
                for (int s = 0; s < dir_cnt && space < int'(op.needed_bytes); s++) begin
                    i = (op.opcode == sld_pkg::OP_LEND_TAIL) ? dir_cnt - 1 - s : s;
                    if (!dir_q[i].dead) begin
                        sz = int'(dir_q[i].len) + SLOT_SZ;
                        used -= sz;
                        if (used <= thresh_reg) break;
                        space += sz;
                        taken++;
                        if (space >= int'(op.needed_bytes)) begin
                            r.result_status = sld_pkg::ST_DONE;
                            r.lend_count = 9'(taken);
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 result_count, what, got, want);
        fail_count++;
    endtask

    // result checker, honouring receiver-side stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                sld_pkg::t_out want;
                want = pending_results.pop_front();
                if (o_out_data.result_status != want.result_status)
                    report_mismatch("result_status", o_out_data.result_status,
                                    want.result_status);
                if (o_out_data.tuple_start != want.tuple_start)
                    report_mismatch("tuple_start", o_out_data.tuple_start, want.tuple_start);
                if (o_out_data.tuple_end != want.tuple_end)
                    report_mismatch("tuple_end", o_out_data.tuple_end, want.tuple_end);
                if (o_out_data.written_bytes != want.written_bytes)
                    report_mismatch("written_bytes", o_out_data.written_bytes,
                                    want.written_bytes);
                if (o_out_data.lend_count != want.lend_count)
                    report_mismatch("lend_count", o_out_data.lend_count, want.lend_count);
                if (o_out_data.did_compact != want.did_compact)
                    report_mismatch("did_compact", o_out_data.did_compact, want.did_compact);
            end
            result_count++;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_off_len <= 0;
        end else if (hold_off_len > 0) begin
            hold_off_len <= hold_off_len - 1;
            i_out_stall <= 1'b1;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_off_len <= 3000;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_op(sld_pkg::t_in op, bit no_gap = 1'b0);
        int g;
        sld_pkg::t_out r;
        g = no_gap ? 0 : gap_len();
        repeat (g) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = apply_page_op(op);
        pending_results.push_back(r);
        if (op.opcode == sld_pkg::OP_INSERT && r.result_status == sld_pkg::ST_TRUNC)
            trunc_seen++;
        if (op.opcode == sld_pkg::OP_INSERT && r.result_status == sld_pkg::ST_REFUSED)
            refuse_seen++;
        if (r.did_compact) compact_seen++;
        if (op.opcode >= sld_pkg::OP_LEND_TAIL && op.opcode <= sld_pkg::OP_LEND_HEAD &&
            r.result_status == sld_pkg::ST_DONE) lend_ok_seen++;
        if (op.opcode == sld_pkg::OP_INSERT && r.result_status != sld_pkg::ST_REFUSED)
            used_keys.push_back(op.search_key);
        item_count++;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (1600) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 13'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == sld_pkg::CFG_UNDERFLOW) thresh_reg = val;
        else max_entry_reg = val;
        @(posedge i_clk);
    endtask

    function automatic sld_pkg::t_in mk(logic [2:0] opc, int key, int plen, int need);
        sld_pkg::t_in t;
        t.opcode = opc;
        t.search_key = 16'(key);
        t.payload_length = 13'(plen);
        t.needed_bytes = 13'(need);
        return t;
    endfunction

    function automatic int pick_key();
        if (used_keys.size() != 0 && $urandom_range(0, 99) < 60)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return $urandom_range(0, 65535);
    endfunction

    task automatic test_directed();
        send_op(mk(sld_pkg::OP_SEARCH, 100, 0, 0));
        send_op(mk(sld_pkg::OP_DELETE, 100, 0, 0));
        send_op(mk(sld_pkg::OP_LEND_TAIL, 0, 0, 1));
        send_op(mk(sld_pkg::OP_INSERT, 100, 20, 0));
        send_op(mk(sld_pkg::OP_INSERT, 0, 0, 0));
        send_op(mk(sld_pkg::OP_INSERT, 65535, 8191, 8191));
        send_op(mk(sld_pkg::OP_INSERT, 50, 40, 0));
        send_op(mk(sld_pkg::OP_SEARCH, 100, 0, 0));
        send_op(mk(sld_pkg::OP_SEARCH, 99, 0, 0));
        send_op(mk(sld_pkg::OP_DELETE, 50, 0, 0));
        send_op(mk(sld_pkg::OP_INSERT, 60, 30, 0));
        send_op(mk(sld_pkg::OP_DELETE, 65535, 0, 0));
        send_op(mk(sld_pkg::OP_INSERT, 70, 4096, 0));
        send_op(mk(sld_pkg::OP_INSERT, 80, 4096, 0));
        send_op(mk(sld_pkg::OP_INSERT, 90, 4096, 0));
        send_op(mk(sld_pkg::OP_LEND_HEAD, 0, 0, 0));
        send_op(mk(sld_pkg::OP_LEND_HEAD, 0, 0, 40));
        send_op(mk(sld_pkg::OP_LEND_TAIL, 0, 0, 8191));
        send_op(mk(3'd5, 65535, 8191, 8191));
        send_op(mk(3'd7, 0, 0, 0));
        send_op(mk(3'd6, 12345, 1, 1));
        wait_drained();
    endtask

    task automatic test_extreme_config();
        write_reg(sld_pkg::CFG_UNDERFLOW, 0);
        write_reg(sld_pkg::CFG_MAX_ENTRY, 8191);
        send_op(mk(sld_pkg::OP_LEND_TAIL, 0, 0, 100));
        send_op(mk(sld_pkg::OP_LEND_HEAD, 0, 0, 8191));
        send_op(mk(sld_pkg::OP_INSERT, 500, 8191, 0));
        send_op(mk(sld_pkg::OP_INSERT, 501, 5, 0));
        wait_drained();
        write_reg(sld_pkg::CFG_UNDERFLOW, 8191);
        write_reg(sld_pkg::CFG_MAX_ENTRY, 0);
        send_op(mk(sld_pkg::OP_INSERT, 502, 5, 0));
        send_op(mk(sld_pkg::OP_LEND_HEAD, 0, 0, 1));
        wait_drained();
        write_reg(sld_pkg::CFG_MAX_ENTRY, 15);
        send_op(mk(sld_pkg::OP_INSERT, 503, 5, 0));
        wait_drained();
        write_reg(sld_pkg::CFG_MAX_ENTRY, 16);
        send_op(mk(sld_pkg::OP_INSERT, 504, 5, 0));
        wait_drained();
    endtask

    task automatic run_random(int n, bit small_rows);
        int p, op_kind;
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(0, 99);
            if (p < 40)
                send_op(mk(sld_pkg::OP_INSERT, pick_key(),
                           small_rows ? $urandom_range(0, 8) :
                           ($urandom_range(0, 9) == 0 ? $urandom_range(0, 8191)
                                                      : $urandom_range(0, 200)), 0));
            else if (p < 60)
                send_op(mk(sld_pkg::OP_SEARCH, pick_key(), $urandom_range(0, 8191), 0));
            else if (p < 78)
                send_op(mk(sld_pkg::OP_DELETE, pick_key(), 0, $urandom_range(0, 8191)));
            else if (p < 96) begin
                op_kind = $urandom_range(0, 1);
                send_op(mk(op_kind ? sld_pkg::OP_LEND_HEAD : sld_pkg::OP_LEND_TAIL,
                           $urandom_range(0, 65535),
                           $urandom_range(0, 8191),
                           $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191)
                                                     : $urandom_range(0, 600)));
            end else
                send_op(mk(3'($urandom_range(5, 7)), $urandom_range(0, 65535),
                           $urandom_range(0, 8191), $urandom_range(0, 8191)));
        end
    endtask

    task automatic test_random_mixed();
        write_reg(sld_pkg::CFG_UNDERFLOW, 300);
        write_reg(sld_pkg::CFG_MAX_ENTRY, 600);
        run_random(150, 1'b0);
        wait_drained();
        write_reg(sld_pkg::CFG_UNDERFLOW, 1024);
        write_reg(sld_pkg::CFG_MAX_ENTRY, 2048);
        run_random(100, 1'b0);
        wait_drained();
    endtask

    task automatic test_directory_fill();
        write_reg(sld_pkg::CFG_UNDERFLOW, 50);
        write_reg(sld_pkg::CFG_MAX_ENTRY, 4096);
        run_random(120, 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off_req = 1'b1;
        for (int k = 0; k < 6; k++)
            send_op(mk(sld_pkg::OP_SEARCH, pick_key(), 0, 0), 1'b1);
        wait_drained();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data  = '0;
        hold_off_req = 1'b0;
        fail_count = 0;
        result_count = 0;
        item_count = 0;
        idle_cycles = 0;
        dir_cnt = 0;
        page_free_end = PAGE - 1;
        page_garbage = 0;
        thresh_reg = 1024;
        max_entry_reg = 2048;
        trunc_seen = 0;
        refuse_seen = 0;
        compact_seen = 0;
        lend_ok_seen = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_extreme_config();
        test_backpressure();
        test_random_mixed();
        test_directory_fill();

        $display("Covered %0d transactions, %0d results; slots at end %0d",
                 item_count, result_count, dir_cnt);
        $display("Inserts truncated %0d, refused %0d, compactions %0d, lends granted %0d",
                 trunc_seen, refuse_seen, compact_seen, lend_ok_seen);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[slotted_leaf_directory.f]
+incdir+hdl
hdl/sld_pkg.sv
hdl/sld_slot_ram.sv
hdl/slotted_leaf_directory.sv
tb/sv/slotted_leaf_directory_tb.sv
